// File: rtl/assert_macros.svh
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// Next-cycle implication, ignored while reset is high.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

// Next-cycle implication that is checked during reset too.
`define ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`endif

// File: rtl/cbnp_pkg.sv
package cbnp_pkg;

   // Field widths.
   localparam int CHAR_W  = 8;
   localparam int VALUE_W = 32;
   localparam int LEN_W   = 5;
   localparam int WORD_W  = 64;
   localparam int INDEX_W = 2;
   localparam int DIGIT_W = 4;

   // Largest accepted alphabet length and number of digit slots.
   localparam int MAX_BASE    = 16;
   localparam int DIGIT_SLOTS = 16;
   localparam int SLOTS_WORD  = WORD_W / CHAR_W;

   // Configuration register indexes.
   localparam logic [INDEX_W-1:0] CSR_ALPHA_LOW  = 2'd0;
   localparam logic [INDEX_W-1:0] CSR_ALPHA_HIGH = 2'd1;
   localparam logic [INDEX_W-1:0] CSR_ALPHA_LEN  = 2'd2;

   // Character codes.
   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;

   // Space, or any control byte from tab through carriage return.
   function automatic logic is_space(input logic [CHAR_W-1:0] c);
      return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
   endfunction

   // Byte of digit slot k taken from the two alphabet words.
   function automatic logic [CHAR_W-1:0] digit_byte(input logic [WORD_W-1:0] low_word,
                                                    input logic [WORD_W-1:0] high_word,
                                                    input int k);
      logic [2*WORD_W-1:0] both;
      both = {high_word, low_word};
      return both[k*CHAR_W +: CHAR_W];
   endfunction

   // Alphabet check: length in range, no reserved byte, no duplicate.
   function automatic logic alphabet_valid(input logic [WORD_W-1:0] low_word,
                                           input logic [WORD_W-1:0] high_word,
                                           input logic [LEN_W-1:0] len);
      logic              ok;
      logic [CHAR_W-1:0] ci;
      ok = (len >= LEN_W'(2)) && (len <= LEN_W'(MAX_BASE));
      for (int i = 0; i < DIGIT_SLOTS; i++) begin
         ci = digit_byte(low_word, high_word, i);
         if (LEN_W'(i) < len) begin
            if ((ci == CHAR_NUL) || (ci == CHAR_PLUS) || (ci == CHAR_MINUS) || is_space(ci)) begin
               ok = 1'b0;
            end
            for (int j = i + 1; j < DIGIT_SLOTS; j++) begin
               if ((LEN_W'(j) < len) && (digit_byte(low_word, high_word, j) == ci)) begin
                  ok = 1'b0;
               end
            end
         end
      end
      return ok;
   endfunction

endpackage

// File: rtl/custom_base_number_parser_core.sv
// Number parser with a configurable digit alphabet.
// The req channel carries one string byte per request in req_tdata, and
// req_tlast marks the final byte of a string. Leading whitespace is skipped,
// a run of '+' and '-' sets the sign, and digits accumulate in the base
// given by the alphabet length until the first byte outside the alphabet.
// On the final byte one response leaves on rsp: the signed 32-bit value in
// rsp_tdata and the alphabet check flag in rsp_tuser (value 0 when the
// alphabet fails the check). Bytes without req_tlast give no response.
// Throughput is one byte per cycle while no final byte waits on a stalled
// rsp: each byte passes an input register and then the digit match,
// multiply by the base and add; the accumulator feedback through that
// multiply-add is what sets the rate. The final byte's response is written
// to the result register that drives rsp_tvalid once the result slot is free.
// When rsp stalls, the response is held; non-final bytes keep flowing and a
// final byte waits in the input register, which then drops req_tready.
// The csr channel is always ready; write it only while no string is in flight.
// Reset is synchronous: it clears the alphabet registers (invalid alphabet),
// the parse state and both valid flags.
module custom_base_number_parser_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [cbnp_pkg::CHAR_W-1:0]     req_tdata,   // [7:0] text_char
   input  logic                            req_tlast,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [cbnp_pkg::VALUE_W-1:0]    rsp_tdata,   // [31:0] parsed_value
   output logic                            rsp_tuser,   // [0] alphabet_ok
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [cbnp_pkg::INDEX_W-1:0]    csr_index,
   input  logic [cbnp_pkg::WORD_W-1:0]     csr_data
);

   typedef enum logic [1:0] {
      PH_SPACE,
      PH_SIGN,
      PH_DIGITS,
      PH_DONE
   } phase_type;

   localparam int PROD_W = cbnp_pkg::VALUE_W + cbnp_pkg::LEN_W;

   // Configuration registers and registered alphabet check.
   logic [cbnp_pkg::WORD_W-1:0]  alpha_low_ff;
   logic [cbnp_pkg::WORD_W-1:0]  alpha_low_in;
   logic [cbnp_pkg::WORD_W-1:0]  alpha_high_ff;
   logic [cbnp_pkg::WORD_W-1:0]  alpha_high_in;
   logic [cbnp_pkg::LEN_W-1:0]   alpha_len_ff;
   logic [cbnp_pkg::LEN_W-1:0]   alpha_len_in;
   logic                         alpha_ok_ff;
   logic                         alpha_ok_in;

   // Input register.
   logic                         in_valid_ff;
   logic [cbnp_pkg::CHAR_W-1:0]  in_char_ff;
   logic                         in_last_ff;

   // Parse state.
   phase_type                    phase_ff;
   phase_type                    phase_in;
   logic                         neg_ff;
   logic                         neg_in;
   logic [cbnp_pkg::VALUE_W-1:0] acc_ff;
   logic [cbnp_pkg::VALUE_W-1:0] acc_in;

   // Result register.
   logic                         rsp_valid_ff;
   logic [cbnp_pkg::VALUE_W-1:0] rsp_value_ff;
   logic                         rsp_ok_ff;

   logic                         rsp_free;
   logic                         proc_fire;
   logic                         digit_found;
   logic [cbnp_pkg::DIGIT_W-1:0] digit_idx;
   logic [PROD_W-1:0]            product;
   logic [cbnp_pkg::VALUE_W-1:0] value_in;

   assign csr_ready = 1'b1;

   // Handshake: the input register moves on unless a final byte meets a full result slot.
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign proc_fire  = in_valid_ff && (!in_last_ff || rsp_free);
   assign req_tready = !in_valid_ff || proc_fire;

   // Next register contents; indexes beyond the list are ignored.
   always_comb begin
      alpha_low_in  = alpha_low_ff;
      alpha_high_in = alpha_high_ff;
      alpha_len_in  = alpha_len_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            cbnp_pkg::CSR_ALPHA_LOW:  alpha_low_in  = csr_data;
            cbnp_pkg::CSR_ALPHA_HIGH: alpha_high_in = csr_data;
            cbnp_pkg::CSR_ALPHA_LEN:  alpha_len_in  = csr_data[cbnp_pkg::LEN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // The check is taken on the next register contents, so it always matches them.
   assign alpha_ok_in = cbnp_pkg::alphabet_valid(alpha_low_in, alpha_high_in, alpha_len_in);

   // Parallel match of the byte against every active digit slot, lowest slot wins.
   always_comb begin
      digit_found = 1'b0;
      digit_idx   = '0;
      for (int k = cbnp_pkg::DIGIT_SLOTS - 1; k >= 0; k--) begin
         if ((cbnp_pkg::LEN_W'(k) < alpha_len_ff) &&
             (cbnp_pkg::digit_byte(alpha_low_ff, alpha_high_ff, k) == in_char_ff)) begin
            digit_found = 1'b1;
            digit_idx   = cbnp_pkg::DIGIT_W'(k);
         end
      end
   end

   assign product = {{cbnp_pkg::LEN_W{1'b0}}, acc_ff} *
                    {{cbnp_pkg::VALUE_W{1'b0}}, alpha_len_ff};

   // Next parse state for the byte in the input register.
   always_comb begin
      phase_in = phase_ff;
      neg_in   = neg_ff;
      acc_in   = acc_ff;
      if ((phase_in == PH_SPACE) && !cbnp_pkg::is_space(in_char_ff)) begin
         phase_in = PH_SIGN;
      end
      if (phase_in == PH_SIGN) begin
         if (in_char_ff == cbnp_pkg::CHAR_MINUS) begin
            neg_in = ~neg_in;
         end else if (in_char_ff != cbnp_pkg::CHAR_PLUS) begin
            phase_in = PH_DIGITS;
         end
      end
      if (phase_in == PH_DIGITS) begin
         if (digit_found) begin
            acc_in = product[cbnp_pkg::VALUE_W-1:0] +
                     {{(cbnp_pkg::VALUE_W - cbnp_pkg::DIGIT_W){1'b0}}, digit_idx};
         end else begin
            phase_in = PH_DONE;
         end
      end
      value_in = neg_in ? (cbnp_pkg::VALUE_W'(0) - acc_in) : acc_in;
   end

   // Configuration registers and the alphabet check flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_low_ff  <= '0;
         alpha_high_ff <= '0;
         alpha_len_ff  <= '0;
         alpha_ok_ff   <= 1'b0;
      end else begin
         alpha_low_ff  <= alpha_low_in;
         alpha_high_ff <= alpha_high_in;
         alpha_len_ff  <= alpha_len_in;
         alpha_ok_ff   <= alpha_ok_in;
      end
   end

   // Input byte payload.
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_char_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   // Parse state, valid flags and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         phase_ff     <= PH_SPACE;
         neg_ff       <= 1'b0;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (proc_fire && in_last_ff) begin
            phase_ff     <= PH_SPACE;
            neg_ff       <= 1'b0;
            acc_ff       <= '0;
            rsp_valid_ff <= 1'b1;
            rsp_value_ff <= alpha_ok_ff ? value_in : '0;
            rsp_ok_ff    <= alpha_ok_ff;
         end else begin
            if (proc_fire) begin
               phase_ff <= phase_in;
               neg_ff   <= neg_in;
               acc_ff   <= acc_in;
            end
            if (rsp_tready) begin
               rsp_valid_ff <= 1'b0;
            end
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_ok_ff;

endmodule

// File: rtl/cbnp_checker.sv
`include "assert_macros.svh"

module cbnp_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_tvalid,
   input logic                         rsp_tready,
   input logic [cbnp_pkg::VALUE_W-1:0] rsp_tdata,
   input logic                         rsp_tuser,
   input logic                         csr_valid,
   input logic                         csr_ready
);

   logic                         rsp_stall;
   logic [cbnp_pkg::VALUE_W:0]   rsp_word;

   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign rsp_word  = {rsp_tuser, rsp_tdata};

   // A stalled response keeps its value and flag.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_word))

   // A failed alphabet check always reports a zero value.
   `ASSERT_IMPLIES(a_bad_alpha_zero, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tdata == '0)

   // Reset leaves no response pending.
   `ASSERT_NEXT_ALWAYS(a_reset_clears, clock, reset, !rsp_tvalid)

   // The configuration channel never pushes back.
   `ASSERT_IMPLIES(a_csr_always_ready, clock, reset, csr_valid, csr_ready)

endmodule

bind custom_base_number_parser_core cbnp_checker u_cbnp_checker (.*);

// File: tb/tb_custom_base_number_parser_core.sv
module tb_custom_base_number_parser_core;
   import cbnp_pkg::*;

   // Index past the register list; writes to it must leave the block unchanged.
   localparam logic [INDEX_W-1:0] CSR_UNUSED = 2'd3;

   localparam int IDLE_PERCENT    = 23;
   localparam int RANDOM_PHASES   = 12;
   localparam int ITEMS_PER_PHASE = 140;
   localparam int STEADY_PHASE    = 6;
   localparam int SETTLE_CYCLES   = 4;
   localparam int QUIET_LIMIT     = 2000;

   typedef enum logic [1:0] {
      SCAN_SPACE,
      SCAN_SIGN,
      SCAN_DIGITS,
      SCAN_DONE
   } scan_phase_type;

   typedef enum int {
      BAD_LENGTH,
      BAD_RESERVED,
      BAD_REPEAT
   } alphabet_fault_type;

   typedef struct packed {
      logic [CHAR_W-1:0] text_char;
      logic              last_char;
   } text_item_type;

   typedef struct packed {
      logic [VALUE_W-1:0] parsed_value;
      logic               alphabet_ok;
   } parsed_number_type;

   logic                clock;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [CHAR_W-1:0]   req_tdata  = '0;   // [7:0] text_char
   logic                req_tlast  = 1'b0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [VALUE_W-1:0]  rsp_tdata;         // [31:0] parsed_value
   logic                rsp_tuser;         // [0] alphabet_ok
   logic                csr_valid  = 1'b0;
   logic                csr_ready;
   logic [INDEX_W-1:0]  csr_index  = '0;
   logic [WORD_W-1:0]   csr_data   = '0;

   // Shadow copy of the alphabet registers.
   logic [WORD_W-1:0]   alpha_low  = '0;
   logic [WORD_W-1:0]   alpha_high = '0;
   logic [LEN_W-1:0]    alpha_len  = '0;

   // Shadow parse state.
   scan_phase_type      scan_phase;
   logic                scan_negative;
   logic [VALUE_W-1:0]  scan_acc;

   text_item_type       char_queue[$];
   parsed_number_type   pending_numbers[$];
   text_item_type       next_item;
   parsed_number_type   want;
   logic                steady_run = 1'b0;
   int                  mismatch_count = 0;
   int                  quiet_cycles;

   custom_base_number_parser_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Character classes used by both the predictor and the string generator.
   function automatic logic blank_char(input logic [CHAR_W-1:0] c);
      return (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
   endfunction

   function automatic logic reserved_char(input logic [CHAR_W-1:0] c);
      return (c == CHAR_NUL) || (c == CHAR_PLUS) || (c == CHAR_MINUS) || blank_char(c);
   endfunction

   function automatic logic [CHAR_W-1:0] slot_char(input int k);
      if (k < SLOTS_WORD) begin
         return alpha_low[k*CHAR_W +: CHAR_W];
      end
      return alpha_high[(k-SLOTS_WORD)*CHAR_W +: CHAR_W];
   endfunction

   // The alphabet is usable when its length is a real base and its digits are
   // distinct ordinary bytes.
   function automatic logic alphabet_usable();
      logic [CHAR_W-1:0] c;
      if (alpha_len < 2 || alpha_len > MAX_BASE) begin
         return 1'b0;
      end
      for (int i = 0; i < alpha_len; i++) begin
         c = slot_char(i);
         if (reserved_char(c)) begin
            return 1'b0;
         end
         for (int j = i + 1; j < alpha_len; j++) begin
            if (slot_char(j) == c) begin
               return 1'b0;
            end
         end
      end
      return 1'b1;
   endfunction

   // Position of the byte in the alphabet, or -1 when it is not a digit.
   function automatic int digit_of(input logic [CHAR_W-1:0] c);
      int span;
      span = (alpha_len > DIGIT_SLOTS) ? DIGIT_SLOTS : alpha_len;
      for (int i = 0; i < span; i++) begin
         if (slot_char(i) == c) begin
            return i;
         end
      end
      return -1;
   endfunction

   task automatic scan_clear();
      scan_phase    = SCAN_SPACE;
      scan_negative = 1'b0;
      scan_acc      = '0;
   endtask

   // Advance the shadow parser by one byte; the final byte yields a number.
   task automatic parse_char(input logic [CHAR_W-1:0] c, input logic last);
      logic               ok;
      int                 d;
      logic [VALUE_W-1:0] magnitude;
      parsed_number_type  result;
      ok = alphabet_usable();
      if (scan_phase == SCAN_SPACE && !blank_char(c)) begin
         scan_phase = SCAN_SIGN;
      end
      if (scan_phase == SCAN_SIGN) begin
         if (c == CHAR_MINUS) begin
            scan_negative = !scan_negative;
         end else if (c != CHAR_PLUS) begin
            scan_phase = SCAN_DIGITS;
         end
      end
      if (scan_phase == SCAN_DIGITS) begin
         d = digit_of(c);
         if (d < 0) begin
            scan_phase = SCAN_DONE;
         end else begin
            scan_acc = scan_acc * VALUE_W'(alpha_len) + VALUE_W'(d);
         end
      end
      if (last) begin
         magnitude = scan_negative ? (VALUE_W'(0) - scan_acc) : scan_acc;
         result.parsed_value = ok ? magnitude : '0;
         result.alphabet_ok  = ok;
         pending_numbers.push_back(result);
         scan_clear();
      end
   endtask

   // Request driver: predicts every accepted byte and feeds the next one.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         scan_clear();
      end else begin
         if (req_tvalid && req_tready) begin
            parse_char(req_tdata, req_tlast);
         end
         if (!req_tvalid || req_tready) begin
            if (char_queue.size() != 0 &&
                (steady_run || $urandom_range(99) >= IDLE_PERCENT)) begin
               next_item = char_queue.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= next_item.text_char;
               req_tlast  <= next_item.last_char;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: each accepted response must match the oldest prediction.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_numbers.size() == 0) begin
               $error("unexpected response: parsed_value %0d alphabet_ok %0b",
                      $signed(rsp_tdata), rsp_tuser);
               mismatch_count++;
            end else begin
               want = pending_numbers.pop_front();
               if (rsp_tdata !== want.parsed_value) begin
                  $error("parsed_value: expected %0d, actual %0d",
                         $signed(want.parsed_value), $signed(rsp_tdata));
                  mismatch_count++;
               end
               if (rsp_tuser !== want.alphabet_ok) begin
                  $error("alphabet_ok: expected %0b, actual %0b", want.alphabet_ok, rsp_tuser);
                  mismatch_count++;
               end
            end
         end
         rsp_tready <= steady_run || ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   // Watchdog on cycles in which no channel moves anything.
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
                   (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAIL custom_base_number_parser_core");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic push_char(input logic [CHAR_W-1:0] c, input logic last);
      text_item_type item;
      item.text_char = c;
      item.last_char = last;
      char_queue.push_back(item);
   endtask

   // Queue a printable string, marking its final byte as the last one.
   task automatic push_text(input string s);
      for (int k = 0; k < s.len(); k++) begin
         push_char(s[k], k == s.len() - 1);
      end
   endtask

   // One register write; the caller lowers csr_valid after its last write.
   task automatic csr_put(input logic [INDEX_W-1:0] idx, input logic [WORD_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_ALPHA_LOW:  alpha_low  = data;
         CSR_ALPHA_HIGH: alpha_high = data;
         CSR_ALPHA_LEN:  alpha_len  = data[LEN_W-1:0];
         default: ;
      endcase
   endtask

   task automatic load_alphabet(input logic [WORD_W-1:0] lo, input logic [WORD_W-1:0] hi,
                                input logic [LEN_W-1:0] len, input logic poke_unused);
      @(posedge clock);
      csr_put(CSR_ALPHA_LOW, lo);
      csr_put(CSR_ALPHA_HIGH, hi);
      // Upper bits of the length word carry noise that the block must drop.
      csr_put(CSR_ALPHA_LEN, {32'($urandom), 27'($urandom), len});
      if (poke_unused) begin
         csr_put(CSR_UNUSED, {$urandom, $urandom});
      end
      csr_valid <= 1'b0;
   endtask

   // Wait until every byte is taken and every number has come back, then let
   // the pipeline settle before touching the registers.
   task automatic wait_drained();
      do @(negedge clock);
      while (char_queue.size() != 0 || req_tvalid || pending_numbers.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Random alphabet of distinct ordinary bytes, broken on purpose in some phases.
   task automatic build_alphabet(input int phase_no, output logic [WORD_W-1:0] lo,
                                 output logic [WORD_W-1:0] hi, output logic [LEN_W-1:0] len);
      logic [CHAR_W-1:0]  slots [DIGIT_SLOTS];
      logic [CHAR_W-1:0]  c;
      logic               fresh;
      int                 n;
      int                 k;
      alphabet_fault_type fault;
      if (phase_no == 0) begin
         n = 2;
      end else if (phase_no == 1) begin
         n = MAX_BASE;
      end else begin
         n = $urandom_range(MAX_BASE, 2);
      end
      k = 0;
      while (k < n) begin
         c = 8'($urandom);
         fresh = !reserved_char(c);
         for (int j = 0; j < k; j++) begin
            if (slots[j] == c) begin
               fresh = 1'b0;
            end
         end
         if (fresh) begin
            slots[k] = c;
            k++;
         end
      end
      // Slots past the length may hold anything, reserved bytes included.
      for (int j = n; j < DIGIT_SLOTS; j++) begin
         slots[j] = 8'($urandom);
      end
      len = LEN_W'(n);
      if (phase_no % 4 == 3) begin
         fault = alphabet_fault_type'((phase_no / 4) % 3);
         case (fault)
            BAD_LENGTH: begin
               case ($urandom_range(2))
                  0: len = '0;
                  1: len = LEN_W'(1);
                  default: len = LEN_W'($urandom_range(31, MAX_BASE + 1));
               endcase
            end
            BAD_RESERVED: begin
               k = $urandom_range(n - 1);
               case ($urandom_range(3))
                  0: slots[k] = CHAR_NUL;
                  1: slots[k] = CHAR_PLUS;
                  2: slots[k] = CHAR_MINUS;
                  default: slots[k] = ($urandom_range(5) == 0) ? CHAR_SPACE :
                                      8'($urandom_range(CHAR_CR, CHAR_TAB));
               endcase
            end
            default: begin
               k = $urandom_range(n - 1, 1);
               slots[k] = slots[$urandom_range(k - 1)];
            end
         endcase
      end
      for (int j = 0; j < SLOTS_WORD; j++) begin
         lo[j*CHAR_W +: CHAR_W] = slots[j];
         hi[j*CHAR_W +: CHAR_W] = slots[j + SLOTS_WORD];
      end
   endtask

   // Mostly well-formed numbers with random content; the rest is raw noise.
   task automatic queue_string(output int count);
      logic [CHAR_W-1:0] text[$];
      int                span;
      int                n_digit;
      if ($urandom_range(99) < 15) begin
         repeat ($urandom_range(6, 1)) text.push_back(8'($urandom));
      end else begin
         repeat ($urandom_range(3)) begin
            text.push_back(($urandom_range(5) == 0) ? CHAR_SPACE :
                           8'($urandom_range(CHAR_CR, CHAR_TAB)));
         end
         repeat ($urandom_range(3)) begin
            text.push_back($urandom_range(1) ? CHAR_MINUS : CHAR_PLUS);
         end
         span = (alpha_len >= 2 && alpha_len <= MAX_BASE) ? alpha_len : DIGIT_SLOTS;
         n_digit = ($urandom_range(99) < 20) ? $urandom_range(12, 8) : $urandom_range(6);
         repeat (n_digit) text.push_back(slot_char($urandom_range(span - 1)));
         if ($urandom_range(99) < 30) begin
            repeat ($urandom_range(3, 1)) text.push_back(8'($urandom));
         end
      end
      if (text.size() == 0) begin
         text.push_back(8'($urandom));
      end
      for (int k = 0; k < text.size(); k++) begin
         push_char(text[k], k == text.size() - 1);
      end
      count = text.size();
   endtask

   // Stimulus sequence: directed strings, then random phases.
   initial begin
      logic [WORD_W-1:0] lo;
      logic [WORD_W-1:0] hi;
      logic [LEN_W-1:0]  len;
      int                queued;
      int                added;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // The empty alphabet left by reset is rejected.
      @(negedge clock);
      push_char(8'h37, 1'b1);
      wait_drained();

      // Decimal digits: whitespace and sign run, early stop, zero byte, stray byte.
      load_alphabet("76543210", {48'h0, "98"}, LEN_W'(10), 1'b0);
      @(negedge clock);
      push_char(CHAR_SPACE, 1'b0);
      push_char(CHAR_TAB, 1'b0);
      push_char(CHAR_CR, 1'b0);
      push_char(CHAR_MINUS, 1'b0);
      push_char(CHAR_PLUS, 1'b0);
      push_text("42");
      push_text("12x9");
      push_char(8'h33, 1'b0);
      push_char(CHAR_NUL, 1'b0);
      push_char(8'h38, 1'b1);
      push_char(8'hFF, 1'b1);
      wait_drained();

      // Full base with high-bit digits: nine top digits wrap the accumulator.
      load_alphabet("76543210", {8'hFF, 8'h80, "DCBA98"}, LEN_W'(MAX_BASE), 1'b1);
      @(negedge clock);
      repeat (8) push_char(8'hFF, 1'b0);
      push_char(8'hFF, 1'b1);
      wait_drained();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         build_alphabet(p, lo, hi, len);
         steady_run = (p == STEADY_PHASE);
         load_alphabet(lo, hi, len, p[0]);
         @(negedge clock);
         queued = 0;
         while (queued < ITEMS_PER_PHASE) begin
            queue_string(added);
            queued += added;
         end
         wait_drained();
      end
      steady_run = 1'b0;

      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS custom_base_number_parser_core");
      end else begin
         $display("FAIL custom_base_number_parser_core");
      end
      $finish;
   end

endmodule
